// ----- rtl/pearson_correlation_accumulator_macros.svh -----
// Assertion macros for the correlation accumulator back end.
`ifndef PEARSON_CORRELATION_ACCUMULATOR_MACROS_SVH
`define PEARSON_CORRELATION_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PCA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pca_pkg.sv -----
// Shared types and constants of the correlation accumulator.
`default_nettype none
package pca_pkg;

	// Largest correlation magnitude in Q1.15.
	localparam logic [14:0] Q_MAX = 15'd32767;
	// Fraction scale applied to the squared numerator: 2^32 = (2 * 32768)^2.
	localparam int FRAC_SHIFT = 32;

	// Serial multiplier operations of the back end, in issue order.
	typedef enum logic [3:0] {
		OP_NAA = 4'd0,
		OP_SA2 = 4'd1,
		OP_NBB = 4'd2,
		OP_SB2 = 4'd3,
		OP_NAB = 4'd4,
		OP_SAB = 4'd5,
		OP_VV  = 4'd6,
		OP_CC  = 4'd7,
		OP_FIT = 4'd8
	} op_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LOAD = 6'b000010,
		S_MUL  = 6'b000100,
		S_CALC = 6'b001000,
		S_SRCH = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/pca_channels.sv -----
// Handshake channel interfaces: rating pairs in, correlation results out.
`default_nettype none
interface pca_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rating_a;
	logic [7:0] rating_b;
	logic       last;

	modport source (output valid, output rating_a, output rating_b, output last, input ready);
	modport sink (input valid, input rating_a, input rating_b, input last, output ready);
endinterface

interface pca_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] correlation;
	logic               zero_spread;

	modport source (output valid, output correlation, output zero_spread, input ready);
	modport sink (input valid, input correlation, input zero_spread, output ready);
endinterface
`default_nettype wire

// ----- rtl/pearson_correlation_accumulator.sv -----
// Pearson correlation accumulator: streams rating pairs, returns one coefficient per vector.
//
// Channels: samples (rating_a, rating_b, last) in, results (correlation, zero_spread) out,
// both valid/ready; a transaction completes on a clock edge with valid and ready high.
// The front end takes one pair per cycle while the queue has room and keeps exact sums of a, b, a*a, b*b, a*b and
// the pair count (pairs beyond MAX_LENGTH are dropped). A pair with last set closes the
// vector: its sums go into a two-entry queue and the accumulators clear.
// The back end works one vector at a time on a single shift-add multiplier that takes
// one multiplier bit per cycle over max(PW, 32) bits, PW = count bits + square-sum bits
// (38 at the defaults). Eight products form the spreads, then a 15-step binary search
// on the Q1.15 magnitude needs one product per step, each step with its pass through
// the search state. When the spread is zero, the result follows the first six products
// and no search is run.
// Result: correlation in Q1.15, rounded to nearest, within +/-32767; zero_spread flags a
// zero denominator and forces 0.
// When results stalls, one result waits in the output register, one more in the back end
// and two vectors in the queue; the front end then holds ready low.
// Reset (arst_n low) clears the sums, queue, sequencer and output valid.
`default_nettype none
module pearson_correlation_accumulator import pca_pkg::*; #(
	parameter int MAX_LENGTH  = 1024,
	parameter int RATING_BITS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pca_in_if.sink    samples,
	pca_out_if.source results
);

	localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
	localparam int RB_EFF = (RATING_BITS < 8) ? RATING_BITS : 8;
	localparam int SUM_W  = RB_EFF + CNT_W;
	localparam int SQ_W   = 2 * RB_EFF + CNT_W;
	localparam int SNAP_W = CNT_W + 2 * SUM_W + 3 * SQ_W;

	logic              f_valid, f_ready, b_valid, b_ready;
	logic [SNAP_W-1:0] f_snap, b_snap;

	pca_front #(
		.MAX_LENGTH  (MAX_LENGTH),
		.RATING_BITS (RATING_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.snap_valid (f_valid),
		.snap_ready (f_ready),
		.snap       (f_snap)
	);

	pca_fifo #(
		.WIDTH (SNAP_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_snap),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_snap)
	);

	pca_back #(
		.MAX_LENGTH  (MAX_LENGTH),
		.RATING_BITS (RATING_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (b_valid),
		.snap_ready (b_ready),
		.snap       (b_snap),
		.results    (results)
	);

endmodule
`default_nettype wire

// ----- rtl/pca_front.sv -----
// Front end: accepts rating pairs and keeps the running sums and count.
`default_nettype none
module pca_front import pca_pkg::*; #(
	parameter int MAX_LENGTH  = 1024,
	parameter int RATING_BITS = 8,
	localparam int CNT_W  = $clog2(MAX_LENGTH + 1),
	localparam int RB_EFF = (RATING_BITS < 8) ? RATING_BITS : 8,
	localparam int SUM_W  = RB_EFF + CNT_W,
	localparam int SQ_W   = 2 * RB_EFF + CNT_W,
	localparam int SNAP_W = CNT_W + 2 * SUM_W + 3 * SQ_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	pca_in_if.sink                 samples,
	output logic                   snap_valid,
	input  wire logic              snap_ready,
	output logic [SNAP_W-1:0]      snap
);

	logic [CNT_W-1:0]  cnt_q, cnt_nx;
	logic [SUM_W-1:0]  sa_q, sb_q, sa_nx, sb_nx;
	logic [SQ_W-1:0]   saa_q, sbb_q, sab_q, saa_nx, sbb_nx, sab_nx;
	logic [RB_EFF-1:0] a, b;
	logic              room, take;

	assign a    = samples.rating_a[RB_EFF-1:0];
	assign b    = samples.rating_b[RB_EFF-1:0];
	assign room = cnt_q < CNT_W'(MAX_LENGTH);
	assign take = samples.valid & samples.ready;

	// Only a last pair needs queue space, but holding all pairs keeps ready simple.
	assign samples.ready = snap_ready;

	always_comb begin
		cnt_nx = cnt_q;
		sa_nx  = sa_q;
		sb_nx  = sb_q;
		saa_nx = saa_q;
		sbb_nx = sbb_q;
		sab_nx = sab_q;
		if (room) begin
			cnt_nx = cnt_q + CNT_W'(1);
			sa_nx  = sa_q + SUM_W'(a);
			sb_nx  = sb_q + SUM_W'(b);
			saa_nx = saa_q + SQ_W'(a) * SQ_W'(a);
			sbb_nx = sbb_q + SQ_W'(b) * SQ_W'(b);
			sab_nx = sab_q + SQ_W'(a) * SQ_W'(b);
		end
	end

	assign snap_valid = take & samples.last;
	assign snap       = {cnt_nx, sa_nx, sb_nx, saa_nx, sbb_nx, sab_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
			saa_q <= '0;
			sbb_q <= '0;
			sab_q <= '0;
		end else if (take) begin
			if (samples.last) begin
				cnt_q <= '0;
				sa_q  <= '0;
				sb_q  <= '0;
				saa_q <= '0;
				sbb_q <= '0;
				sab_q <= '0;
			end else begin
				cnt_q <= cnt_nx;
				sa_q  <= sa_nx;
				sb_q  <= sb_nx;
				saa_q <= saa_nx;
				sbb_q <= sbb_nx;
				sab_q <= sab_nx;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pca_fifo.sv -----
// Two-entry queue carrying finished sums from front end to back end.
`default_nettype none
module pca_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q, rd_q;
	logic [1:0]       cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != 2'd2;
	assign pop_valid  = cnt_q != 2'd0;
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pca_back.sv -----
// Back end: serial shift-add multiplier, spread terms and binary search of the quotient.
`default_nettype none
module pca_back import pca_pkg::*; #(
	parameter int MAX_LENGTH  = 1024,
	parameter int RATING_BITS = 8,
	localparam int CNT_W  = $clog2(MAX_LENGTH + 1),
	localparam int RB_EFF = (RATING_BITS < 8) ? RATING_BITS : 8,
	localparam int SUM_W  = RB_EFF + CNT_W,
	localparam int SQ_W   = 2 * RB_EFF + CNT_W,
	localparam int SNAP_W = CNT_W + 2 * SUM_W + 3 * SQ_W
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              snap_valid,
	output logic                   snap_ready,
	input  wire logic [SNAP_W-1:0] snap,
	pca_out_if.source              results
);

	`include "pearson_correlation_accumulator_macros.svh"

	localparam int PW    = CNT_W + SQ_W;
	localparam int BIG_W = 2 * PW + FRAC_SHIFT;
	localparam int MB_W  = (PW > 32) ? PW : 32;
	localparam int BC_W  = $clog2(MB_W);

	state_t state_q;
	op_t    op_q;

	logic [CNT_W-1:0] n_q;
	logic [SUM_W-1:0] sa_q, sb_q;
	logic [SQ_W-1:0]  saa_q, sbb_q, sab_q;

	logic [PW-1:0]    naa_q, sa2_q, nbb_q, sb2_q, nab_q, sab2_q;
	logic [PW-1:0]    va_q, vb_q, cm_q, va, vb, cm;
	logic             neg_q, neg;
	logic [2*PW-1:0]  d_q;
	logic [BIG_W-1:0] r_q;

	logic [BIG_W-1:0] a_sh_q, acc_q, acc_nx, a_op;
	logic [MB_W-1:0]  b_sh_q, b_op;
	logic [BC_W-1:0]  bit_cnt_q;
	logic             last_bit;

	logic [14:0] lo_q, hi_q, mid_q, mid;
	logic [15:0] mid_sum, odd;
	logic [31:0] odd_sq;

	logic signed [15:0] res_corr_q, corr_q;
	logic               res_zs_q, zs_q, out_valid_q, out_free;

	assign snap_ready = state_q == S_IDLE;
	assign out_free   = !out_valid_q || results.ready;

	assign results.valid       = out_valid_q;
	assign results.correlation = corr_q;
	assign results.zero_spread = zs_q;

	// Probe point for the search: odd = 2*mid - 1, tested as odd^2 * D <= C^2 * 2^32.
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + 16'd1;
	assign mid     = mid_sum[15:1];
	assign odd     = {mid, 1'b0} - 16'd1;
	assign odd_sq  = odd * odd;

	always_comb begin
		a_op = '0;
		b_op = '0;
		unique case (op_q)
			OP_NAA: begin a_op = BIG_W'(saa_q); b_op = MB_W'(n_q);  end
			OP_SA2: begin a_op = BIG_W'(sa_q);  b_op = MB_W'(sa_q); end
			OP_NBB: begin a_op = BIG_W'(sbb_q); b_op = MB_W'(n_q);  end
			OP_SB2: begin a_op = BIG_W'(sb_q);  b_op = MB_W'(sb_q); end
			OP_NAB: begin a_op = BIG_W'(sab_q); b_op = MB_W'(n_q);  end
			OP_SAB: begin a_op = BIG_W'(sa_q);  b_op = MB_W'(sb_q); end
			OP_VV:  begin a_op = BIG_W'(va_q);  b_op = MB_W'(vb_q); end
			OP_CC:  begin a_op = BIG_W'(cm_q);  b_op = MB_W'(cm_q); end
			OP_FIT: begin a_op = BIG_W'(d_q);   b_op = MB_W'(odd_sq); end
			default: begin a_op = '0; b_op = '0; end
		endcase
	end

	assign acc_nx   = acc_q + (b_sh_q[0] ? a_sh_q : '0);
	assign last_bit = bit_cnt_q == BC_W'(MB_W - 1);

	assign va  = (naa_q > sa2_q) ? naa_q - sa2_q : '0;
	assign vb  = (nbb_q > sb2_q) ? nbb_q - sb2_q : '0;
	assign neg = nab_q < sab2_q;
	assign cm  = neg ? sab2_q - nab_q : nab_q - sab2_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && snap_valid) begin
			{n_q, sa_q, sb_q, saa_q, sbb_q, sab_q} <= snap;
		end
		if (state_q == S_LOAD) begin
			a_sh_q <= a_op;
			b_sh_q <= b_op;
			acc_q  <= '0;
			mid_q  <= mid;
		end
		if (state_q == S_MUL) begin
			a_sh_q <= a_sh_q << 1;
			b_sh_q <= b_sh_q >> 1;
			acc_q  <= acc_nx;
			if (last_bit) begin
				unique case (op_q)
					OP_NAA:  naa_q  <= acc_nx[PW-1:0];
					OP_SA2:  sa2_q  <= acc_nx[PW-1:0];
					OP_NBB:  nbb_q  <= acc_nx[PW-1:0];
					OP_SB2:  sb2_q  <= acc_nx[PW-1:0];
					OP_NAB:  nab_q  <= acc_nx[PW-1:0];
					OP_SAB:  sab2_q <= acc_nx[PW-1:0];
					OP_VV:   d_q    <= acc_nx[2*PW-1:0];
					OP_CC:   r_q    <= acc_nx << FRAC_SHIFT;
					default: r_q    <= r_q;
				endcase
			end
		end
		if (state_q == S_CALC) begin
			va_q  <= va;
			vb_q  <= vb;
			cm_q  <= cm;
			neg_q <= neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NAA;
			bit_cnt_q   <= '0;
			lo_q        <= '0;
			hi_q        <= Q_MAX;
			res_corr_q  <= '0;
			res_zs_q    <= 1'b0;
			corr_q      <= '0;
			zs_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (results.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (snap_valid) begin
						op_q    <= OP_NAA;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					bit_cnt_q <= '0;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					bit_cnt_q <= bit_cnt_q + BC_W'(1);
					if (last_bit) begin
						bit_cnt_q <= '0;
						unique case (op_q)
							OP_NAA: begin op_q <= OP_SA2; state_q <= S_LOAD; end
							OP_SA2: begin op_q <= OP_NBB; state_q <= S_LOAD; end
							OP_NBB: begin op_q <= OP_SB2; state_q <= S_LOAD; end
							OP_SB2: begin op_q <= OP_NAB; state_q <= S_LOAD; end
							OP_NAB: begin op_q <= OP_SAB; state_q <= S_LOAD; end
							OP_SAB: state_q <= S_CALC;
							OP_VV:  begin op_q <= OP_CC; state_q <= S_LOAD; end
							OP_CC: begin
								lo_q    <= '0;
								hi_q    <= Q_MAX;
								op_q    <= OP_FIT;
								state_q <= S_SRCH;
							end
							OP_FIT: begin
								if (acc_nx <= r_q) lo_q <= mid_q;
								else               hi_q <= mid_q - 15'd1;
								state_q <= S_SRCH;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CALC: begin
					if (va == '0 || vb == '0) begin
						res_corr_q <= '0;
						res_zs_q   <= 1'b1;
						state_q    <= S_DONE;
					end else begin
						op_q    <= OP_VV;
						state_q <= S_LOAD;
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_LOAD;
					end else begin
						res_corr_q <= neg_q ? -$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});
						res_zs_q   <= 1'b0;
						state_q    <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						corr_q      <= res_corr_q;
						zs_q        <= res_zs_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PCA_ASSERT_IMPL(a_search_order, state_q == S_SRCH, lo_q <= hi_q, "search bounds crossed")
	`PCA_ASSERT_IMPL(a_zero_flag, results.valid && results.zero_spread, results.correlation == 16'sd0, "zero_spread with nonzero correlation")
	`PCA_ASSERT_IMPL(a_no_min, results.valid, results.correlation != 16'sh8000, "correlation out of saturated range")
	`PCA_ASSERT_NEXT(a_done_out, state_q == S_DONE && !out_valid_q, results.valid, "finished result not presented")

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the Pearson correlation accumulator.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAIR_LIMIT   = 1024;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 1000;
	localparam int RANDOM_ITEMS = 110;

	typedef struct packed {
		logic signed [15:0] correlation;
		logic               zero_spread;
	} coef_t;

	typedef struct {
		logic [7:0]         a;
		logic [7:0]         b;
		logic               last;
		logic               typed;
		logic signed [15:0] correlation;
		logic               zero_spread;
	} row_t;

	logic clk;
	logic arst_n;

	pca_in_if  samples_ch ();
	pca_out_if results_ch ();

	pearson_correlation_accumulator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_ch),
		.results (results_ch)
	);

	// running sums of the vector being streamed
	logic [63:0] sum_a, sum_b, sum_aa, sum_bb, sum_ab, pairs;
	coef_t       pending_coefs[$];
	int          mismatches;
	int          idle_cycles;
	logic        calm;

	function automatic coef_t correlate();
		logic [63:0]  naa, sa2, nbb, sb2, nab, sab, va, vb, cm;
		logic [191:0] den_sq, rhs, lhs, odd;
		logic [31:0]  lo, hi, mid;
		logic         neg;
		coef_t        c;
		naa = pairs * sum_aa;
		sa2 = sum_a * sum_a;
		nbb = pairs * sum_bb;
		sb2 = sum_b * sum_b;
		nab = pairs * sum_ab;
		sab = sum_a * sum_b;
		va  = (naa > sa2) ? naa - sa2 : 64'd0;
		vb  = (nbb > sb2) ? nbb - sb2 : 64'd0;
		neg = nab < sab;
		cm  = neg ? sab - nab : nab - sab;
		if (va == 0 || vb == 0) begin
			c.correlation = '0;
			c.zero_spread = 1'b1;
			return c;
		end
		den_sq = 192'(va) * 192'(vb);
		rhs    = (192'(cm) * 192'(cm)) << 32;
		lo = 0;
		hi = 32767;
		// largest q with q - 1/2 <= 32768*|r|
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			odd = 192'(2 * mid - 1);
			lhs = odd * odd * den_sq;
			if (lhs <= rhs) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		c.correlation = neg ? -$signed(16'(lo)) : $signed(16'(lo));
		c.zero_spread = 1'b0;
		return c;
	endfunction

	function automatic void clear_sums();
		sum_a  = 0;
		sum_b  = 0;
		sum_aa = 0;
		sum_bb = 0;
		sum_ab = 0;
		pairs  = 0;
	endfunction

	// returns 1 when the pair closes a vector, with its coefficient
	function automatic logic accumulate(input logic [7:0] a, input logic [7:0] b,
			input logic last, output coef_t c);
		if (pairs < PAIR_LIMIT) begin
			sum_a  += a;
			sum_b  += b;
			sum_aa += a * a;
			sum_bb += b * b;
			sum_ab += a * b;
			pairs  += 1;
		end
		if (!last)
			return 1'b0;
		c = correlate();
		clear_sums();
		return 1'b1;
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send(input row_t r);
		coef_t c;
		int    gap;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 14);
		repeat (gap) begin
			@(negedge clk);
			samples_ch.valid <= 1'b0;
		end
		@(negedge clk);
		samples_ch.valid    <= 1'b1;
		samples_ch.rating_a <= r.a;
		samples_ch.rating_b <= r.b;
		samples_ch.last     <= r.last;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		if (accumulate(r.a, r.b, r.last, c)) begin
			if (r.typed) begin
				c.correlation = r.correlation;
				c.zero_spread = r.zero_spread;
			end
			pending_coefs.push_back(c);
		end
	endtask

	task automatic send_pair(input logic [7:0] a, input logic [7:0] b, input logic last);
		row_t r;
		r = '{a, b, last, 1'b0, 16'sd0, 1'b0};
		send(r);
	endtask

	// result side: random stall bursts, compared at the rising edge
	int stall_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			results_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 13);
			results_ch.ready <= 1'b0;
		end else begin
			results_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		coef_t want;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_coefs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: corr=%0d zero_spread=%0b",
						results_ch.correlation, results_ch.zero_spread);
			end else begin
				want = pending_coefs.pop_front();
				if (results_ch.correlation !== want.correlation ||
						results_ch.zero_spread !== want.zero_spread) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: corr exp %0d got %0d, zero_spread exp %0b got %0b",
							want.correlation, results_ch.correlation,
							want.zero_spread, results_ch.zero_spread);
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	row_t directed[] = '{
		'{8'd0,   8'd0,   1'b1, 1'b1, 16'sd0,      1'b1}, // single pair
		'{8'd255, 8'd255, 1'b1, 1'b1, 16'sd0,      1'b1},
		'{8'd0,   8'd0,   1'b0, 1'b0, 16'sd0,      1'b0},
		'{8'd255, 8'd255, 1'b1, 1'b1, 16'sd32767,  1'b0}, // perfect positive
		'{8'd0,   8'd255, 1'b0, 1'b0, 16'sd0,      1'b0},
		'{8'd255, 8'd0,   1'b1, 1'b1, -16'sd32767, 1'b0}, // perfect negative
		'{8'd7,   8'd1,   1'b0, 1'b0, 16'sd0,      1'b0},
		'{8'd7,   8'd200, 1'b1, 1'b1, 16'sd0,      1'b1}, // constant a
		'{8'd3,   8'd9,   1'b0, 1'b0, 16'sd0,      1'b0},
		'{8'd80,  8'd9,   1'b1, 1'b1, 16'sd0,      1'b1}, // constant b
		'{8'd170, 8'd85,  1'b0, 1'b0, 16'sd0,      1'b0},
		'{8'd85,  8'd170, 1'b0, 1'b0, 16'sd0,      1'b0},
		'{8'd1,   8'd254, 1'b0, 1'b0, 16'sd0,      1'b0},
		'{8'd128, 8'd127, 1'b1, 1'b0, 16'sd0,      1'b0},
		'{8'd10,  8'd20,  1'b0, 1'b0, 16'sd0,      1'b0},
		'{8'd20,  8'd41,  1'b0, 1'b0, 16'sd0,      1'b0},
		'{8'd30,  8'd59,  1'b1, 1'b0, 16'sd0,      1'b0}
	};

	initial begin
		int    sent, len, mode, base;
		logic [7:0] a, b;
		logic  held;
		arst_n = 1'b0;
		calm   = 1'b0;
		held   = 1'b0;
		mismatches  = 0;
		idle_cycles = 0;
		samples_ch.valid    = 1'b0;
		samples_ch.rating_a = '0;
		samples_ch.rating_b = '0;
		samples_ch.last     = 1'b0;
		results_ch.ready    = 1'b0;
		clear_sums();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send(directed[i]);

		// overfull vector at full scale: pairs past the limit are dropped
		for (int i = 0; i < PAIR_LIMIT + 3; i++)
			send_pair(i < PAIR_LIMIT ? 8'(i) : 8'd255, i[0] ? 8'd255 : 8'd0,
				i == PAIR_LIMIT + 2);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (RANDOM_ITEMS - sent < 40)
				calm = 1'b1;
			// hold off once until the back end has drained
			if (!held && sent >= 20) begin
				held = 1'b1;
				@(negedge clk);
				samples_ch.valid <= 1'b0;
				while (pending_coefs.size() != 0)
					@(posedge clk);
			end
			len  = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 14);
			mode = $urandom_range(0, 5);
			base = $urandom_range(0, 255);
			for (int i = 0; i < len; i++) begin
				a = 8'($urandom_range(0, 255));
				case (mode)
					0, 1: b = 8'($urandom_range(0, 255));
					2: b = 8'(a + $urandom_range(0, 15));
					3: b = 8'(255 - a + $urandom_range(0, 7));
					4: begin
						a = 8'(base);
						b = 8'($urandom_range(0, 255));
					end
					default: b = (a > 127) ? 8'd255 : 8'd0;
				endcase
				send_pair(a, b, i == len - 1);
			end
			sent += len;
		end
		@(negedge clk);
		samples_ch.valid <= 1'b0;

		while (pending_coefs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_coefs.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
`default_nettype wire
